FILE: design/lzpd_pkg.sv
`default_nettype none

package lzpd_pkg;

  localparam int unsigned DIST_W = 16;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned WINDOW_DEF    = 4096;
  localparam int unsigned MAX_MATCH_DEF = 64;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_LIT  = 2'd0,
    OP_COPY = 2'd1,
    OP_ERR  = 2'd2
  } lzpd_op_e;

  typedef struct packed {
    lzpd_op_e            op;
    logic [DIST_W-1:0]   offset;
    logic [BYTE_W-1:0]   data;
  } lzpd_entry_t;

endpackage

`default_nettype wire

FILE: design/lzpd_front.sv
`default_nettype none

module lzpd_front #(
  parameter int unsigned WINDOW    = lzpd_pkg::WINDOW_DEF,
  parameter int unsigned MAX_MATCH = lzpd_pkg::MAX_MATCH_DEF
) (
  input  wire logic                        in_valid_i,
  input  wire logic                        pair_valid_i,
  input  wire logic [lzpd_pkg::DIST_W-1:0] distance_i,
  input  wire logic [lzpd_pkg::BYTE_W-1:0] length_or_literal_i,
  input  wire logic                        full_i,
  output logic                             in_stall_o,
  output logic                             push_o,
  output lzpd_pkg::lzpd_entry_t            entry_o
);

  localparam int unsigned CW = lzpd_pkg::DIST_W + 1;

  logic too_far;
  logic too_long;

  assign in_stall_o = full_i;
  // skipped pairs are consumed here and never reach the queue
  assign push_o     = in_valid_i && !full_i && pair_valid_i;

  assign too_far  = {1'b0, distance_i} > CW'(WINDOW);
  assign too_long = length_or_literal_i > lzpd_pkg::BYTE_W'(MAX_MATCH);

  always_comb begin
    entry_o.offset = distance_i;
    entry_o.data   = length_or_literal_i;
    if (distance_i == '0) begin
      entry_o.op = lzpd_pkg::OP_LIT;
    end else if (too_far || too_long) begin
      entry_o.op = lzpd_pkg::OP_ERR;
    end else begin
      // fill check happens in the back part against the live fill count
      entry_o.op = lzpd_pkg::OP_COPY;
    end
  end

endmodule

`default_nettype wire

FILE: design/lzpd_queue.sv
`default_nettype none

module lzpd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire lzpd_pkg::lzpd_entry_t entry_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output logic                       valid_o,
  output lzpd_pkg::lzpd_entry_t      entry_o
);

  lzpd_pkg::lzpd_entry_t             mem_q [lzpd_pkg::QUEUE_DEPTH];
  logic [lzpd_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [lzpd_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [lzpd_pkg::QCNT_W-1:0]       count_q, count_d;

  assign full_o  = count_q == lzpd_pkg::QCNT_W'(lzpd_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/lzpd_back.sv
`default_nettype none

module lzpd_back #(
  parameter int unsigned WINDOW = lzpd_pkg::WINDOW_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire lzpd_pkg::lzpd_entry_t       q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [lzpd_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                             out_last_o,
  output logic                             out_error_o
);

  localparam int unsigned PW = $clog2(WINDOW);
  localparam int unsigned FW = $clog2(WINDOW + 1);
  localparam int unsigned AW = FW + 1;
  localparam int unsigned CW = lzpd_pkg::DIST_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [PW-1:0]                wp_q, wp_d;
  logic [PW-1:0]                rp_q, rp_d;
  logic [FW-1:0]                fill_q, fill_d;
  logic [lzpd_pkg::BYTE_W-1:0]  cnt_q, cnt_d;

  logic                         out_valid_q, out_valid_d;
  logic [lzpd_pkg::BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic                         out_last_q, out_last_d;
  logic                         out_error_q, out_error_d;

  logic [lzpd_pkg::BYTE_W-1:0]  hist_mem [WINDOW];
  logic [lzpd_pkg::BYTE_W-1:0]  rdata_q;
  logic                         mem_we;
  logic                         mem_re;
  logic [lzpd_pkg::BYTE_W-1:0]  mem_wdata;

  logic                         slot_free;
  logic                         beyond_fill;
  logic [AW-1:0]                back_direct;
  logic [AW-1:0]                back_wrap;
  logic [PW-1:0]                start_rp;
  logic                         emit;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign beyond_fill = {1'b0, q_entry_i.offset} > CW'(fill_q);

  // start of the copy, wrapping around the ring
  assign back_direct = AW'(wp_q) - AW'(q_entry_i.offset);
  assign back_wrap   = AW'(wp_q) + AW'(WINDOW) - AW'(q_entry_i.offset);
  assign start_rp    = (AW'(wp_q) >= AW'(q_entry_i.offset)) ? back_direct[PW-1:0]
                                                            : back_wrap[PW-1:0];

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    cnt_d       = cnt_q;
    q_pop_o     = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = rdata_q;
    emit        = 1'b0;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_error_d = out_error_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.op)
            lzpd_pkg::OP_LIT: begin
              if (slot_free) begin
                q_pop_o     = 1'b1;
                mem_we      = 1'b1;
                mem_wdata   = q_entry_i.data;
                emit        = 1'b1;
                out_valid_d = 1'b1;
                out_byte_d  = q_entry_i.data;
                out_last_d  = 1'b1;
                out_error_d = 1'b0;
              end
            end
            lzpd_pkg::OP_COPY: begin
              if (beyond_fill) begin
                if (slot_free) begin
                  q_pop_o     = 1'b1;
                  out_valid_d = 1'b1;
                  out_byte_d  = '0;
                  out_last_d  = 1'b1;
                  out_error_d = 1'b1;
                end
              end else begin
                q_pop_o = 1'b1;
                // a zero-length copy is dropped without a result
                if (q_entry_i.data != '0) begin
                  rp_d    = start_rp;
                  cnt_d   = q_entry_i.data;
                  state_d = ST_READ;
                end
              end
            end
            default: begin
              if (slot_free) begin
                q_pop_o     = 1'b1;
                out_valid_d = 1'b1;
                out_byte_d  = '0;
                out_last_d  = 1'b1;
                out_error_d = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (slot_free) begin
          mem_we      = 1'b1;
          mem_wdata   = rdata_q;
          emit        = 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          out_last_d  = cnt_q == lzpd_pkg::BYTE_W'(1);
          out_error_d = 1'b0;
          cnt_d       = cnt_q - 1'b1;
          rp_d        = (rp_q == PW'(WINDOW - 1)) ? '0 : rp_q + 1'b1;
          state_d     = (cnt_q == lzpd_pkg::BYTE_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (emit) begin
      wp_d = (wp_q == PW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != FW'(WINDOW)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q        <= rp_d;
    cnt_q       <= cnt_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_error_q <= out_error_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= hist_mem[rp_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_error_o = out_error_q;

endmodule

`default_nettype wire

FILE: design/lz77_pair_decoder.sv
`default_nettype none

// LZ77 pair decoder. Each accepted request is one (distance, length/literal)
// pair; pairs with pair_valid_i low are swallowed with no result. A literal
// or a rejected pair (distance beyond the bytes produced so far or beyond
// WINDOW, or length above MAX_MATCH) gives one registered result when it
// reaches the execution side and the result slot is free; a copy of N
// bytes gives N results, each a read of the single-port history ring and
// then a write of the same byte. A two-entry request queue and a result
// register let the input keep flowing while a result is stalled. The ring
// is not cleared after reset; the range checks keep copies on written bytes.
module lz77_pair_decoder #(
  parameter int unsigned WINDOW    = lzpd_pkg::WINDOW_DEF,
  parameter int unsigned MAX_MATCH = lzpd_pkg::MAX_MATCH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        pair_valid_i,
  input  wire logic [lzpd_pkg::DIST_W-1:0] distance_i,
  input  wire logic [lzpd_pkg::BYTE_W-1:0] length_or_literal_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [lzpd_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                             out_last_o,
  output logic                             out_error_o
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  lzpd_pkg::lzpd_entry_t front_entry;
  lzpd_pkg::lzpd_entry_t q_entry;

  lzpd_front #(
    .WINDOW   (WINDOW),
    .MAX_MATCH(MAX_MATCH)
  ) u_front (
    .in_valid_i         (in_valid_i),
    .pair_valid_i       (pair_valid_i),
    .distance_i         (distance_i),
    .length_or_literal_i(length_or_literal_i),
    .full_i             (q_full),
    .in_stall_o         (in_stall_o),
    .push_o             (q_push),
    .entry_o            (front_entry)
  );

  lzpd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(front_entry),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  lzpd_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .out_error_o(out_error_o)
  );

`ifndef SYNTH
  // an error result is always a single zero byte closing its pair
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_error_o |-> out_last_o && out_byte_o == '0)
    else $error("error result without last or with nonzero byte");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a valid pair taken in is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && pair_valid_i |=> q_valid)
    else $error("accepted pair missing from queue");
`endif

endmodule

`default_nettype wire
